@@ sv/tpi_pkg.sv @@
// ----------------------------------------------------------------------------
// tpi_pkg
// Shared types and constants for the tri-port interface with interrupt
// controller: request and result payloads, register state, register map.
// ----------------------------------------------------------------------------
package tpi_pkg;

  // Request action codes
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_LINE  = 2'd2;

  // Register map
  localparam logic [2:0] REG_PA   = 3'd0;
  localparam logic [2:0] REG_PB   = 3'd1;
  localparam logic [2:0] REG_PC   = 3'd2;
  localparam logic [2:0] REG_DDPA = 3'd3;
  localparam logic [2:0] REG_DDPB = 3'd4;
  localparam logic [2:0] REG_DDPC = 3'd5;
  localparam logic [2:0] REG_CREG = 3'd6;
  localparam logic [2:0] REG_AIR  = 3'd7;

  // Control register bits
  localparam int CR_IRQ_MODE = 0;
  localparam int CR_PRIO     = 1;
  localparam int CR_EDGE3    = 2;
  localparam int CR_EDGE4    = 3;
  localparam int CR_CA_LO    = 4;
  localparam int CR_CA_HI    = 5;
  localparam int CR_CB_LO    = 6;
  localparam int CR_CB_HI    = 7;

  // Interrupt lines
  localparam logic [2:0] NUM_LINES = 3'd5;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] addr;
    logic [7:0] write_data;
    logic [7:0] pin_a;
    logic [7:0] pin_b;
    logic [7:0] pin_c;
    logic [2:0] irq_line;
    logic       irq_level;
  } tpi_cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] port_a_out;
    logic [7:0] port_b_out;
    logic [7:0] port_c_out;
    logic       ca_level;
    logic       ca_pulse;
    logic       cb_level;
    logic       cb_pulse;
    logic       irq_out;
  } tpi_rsp_t;

  typedef struct packed {
    logic [7:0] pa;
    logic [7:0] pb;
    logic [7:0] pc;
    logic [7:0] ddpa;
    logic [7:0] ddpb;
    logic [7:0] ddpc;
    logic [7:0] creg;
    logic [7:0] air;
    logic [4:0] line_prev;
    logic [4:0] stack;
    logic [7:0] pc_held;
    logic       ca;
    logic       cb;
  } tpi_state_t;

endpackage

@@ sv/tpi_cmd_if.sv @@
// ----------------------------------------------------------------------------
// tpi_cmd_if
// Request channel: valid/ready handshake carrying one bus access or line edge.
// ----------------------------------------------------------------------------
interface tpi_cmd_if
  import tpi_pkg::*;
();
  logic      valid;
  logic      ready;
  tpi_cmd_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/tpi_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tpi_rsp_if
// Result channel: valid/ready handshake carrying read data and port levels.
// ----------------------------------------------------------------------------
interface tpi_rsp_if
  import tpi_pkg::*;
();
  logic      valid;
  logic      ready;
  tpi_rsp_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/triport_interface_irq_controller_top.sv @@
// Path: a taken request is held in the input register, passes through the
// update and is loaded into the result register, where the sink takes it.
// Throughput: one request per cycle; the input register refills as it drains.
// The only stall is a result register that the sink has not yet taken.
// Reset (rst, synchronous): registers cleared, line history all high,
// port C output 0xff, CA and CB low, both stages empty.
// ----------------------------------------------------------------------------
// triport_interface_irq_controller_top
// Tri-port interface with interrupt controller: input register, single-pass
// register update, result register.
// ----------------------------------------------------------------------------
module triport_interface_irq_controller_top
  import tpi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  tpi_cmd_if.sink    cmd,
  tpi_rsp_if.source  rsp
);

  logic       s1_valid;
  tpi_cmd_t   s1_item;
  tpi_rsp_t   result;
  logic       space;
  logic       advance;

  // move the held request through the update when the result register is free
  assign advance = s1_valid && space;

  tpi_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .advance (advance),
    .valid   (s1_valid),
    .item    (s1_item)
  );

  tpi_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (s1_item),
    .result  (result)
  );

  tpi_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance),
    .result (result),
    .rsp    (rsp),
    .space  (space)
  );

`ifndef SYNTHESIS
  // a pulse always ends with the line back high
  a_ca_pulse_high: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.ca_pulse |-> rsp.data.ca_level)
    else $error("CA pulse without CA high");

  a_cb_pulse_high: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.cb_pulse |-> rsp.data.cb_level)
    else $error("CB pulse without CB high");

  // a read pulses CA, a write pulses CB, never both
  a_pulse_excl: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.data.ca_pulse && rsp.data.cb_pulse))
    else $error("CA and CB pulse from one request");

  // back-pressure only while a result waits
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> rsp.valid && !rsp.ready)
    else $error("request stalled with free result register");
`endif

endmodule

@@ sv/tpi_in_stage.sv @@
// ----------------------------------------------------------------------------
// tpi_in_stage
// Input register: captures one request, refills in the cycle it moves on.
// ----------------------------------------------------------------------------
module tpi_in_stage
  import tpi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  tpi_cmd_if.sink    cmd,
  input  logic       advance,
  output logic       valid,
  output tpi_cmd_t   item
);

  // take a new request when empty or when the held one moves on
  assign cmd.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ready) begin
      valid <= cmd.valid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      item <= cmd.data;
    end
  end

endmodule

@@ sv/tpi_core.sv @@
// ----------------------------------------------------------------------------
// tpi_core
// Register file, line history, interrupt stack and handshake lines, with the
// single-pass update for one request and the result it produces.
// ----------------------------------------------------------------------------
module tpi_core
  import tpi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  tpi_cmd_t   item,
  output tpi_rsp_t   result
);

  // registers clear, line history high, port C output high
  localparam tpi_state_t ST_RESET = '{
    pa:        8'h00,
    pb:        8'h00,
    pc:        8'h00,
    ddpa:      8'h00,
    ddpb:      8'h00,
    ddpc:      8'h00,
    creg:      8'h00,
    air:       8'h00,
    line_prev: 5'h1f,
    stack:     5'h00,
    pc_held:   8'hff,
    ca:        1'b0,
    cb:        1'b0
  };

  tpi_state_t st;
  tpi_state_t st_next;

  // Set a latch; if unmasked, update active register and stack
  function automatic tpi_state_t latch_source(tpi_state_t s, logic [4:0] b);
    tpi_state_t r;
    logic [7:0] bw;
    r  = s;
    bw = {3'b000, b};
    r.pc = r.pc | bw;
    if ((r.ddpc & bw) != 8'h00) begin
      if (r.creg[CR_PRIO]) begin
        if (bw > (r.pc & ~bw)) r.air = bw;
      end else if (r.air == 8'h00) begin
        r.air = bw;
      end
      r.stack = r.stack | b;
    end
    return r;
  endfunction

  // Latch for lines 3 and 4, which also raise CA / CB in toggle mode
  function automatic tpi_state_t edge_latch(tpi_state_t s, logic [4:0] b);
    tpi_state_t r;
    r = latch_source(s, b);
    if (b[3] && (r.creg[CR_CA_HI:CR_CA_LO] == 2'b00)) r.ca = 1'b1;
    if (b[4] && (r.creg[CR_CB_HI:CR_CB_LO] == 2'b00)) r.cb = 1'b1;
    return r;
  endfunction

  logic [7:0] rd;
  logic       cap;
  logic       cbp;
  logic [4:0] bsel;
  logic [4:0] one_hot;
  logic [7:0] v;

  // Next state and result for the request in the input register
  always_comb begin
    st_next = st;
    rd      = 8'h00;
    cap     = 1'b0;
    cbp     = 1'b0;
    bsel    = 5'b00001 << item.irq_line;
    one_hot = 5'b00000;
    v       = item.write_data;
    case (item.action)
      ACT_READ: begin
        case (item.addr)
          REG_PA: begin
            if (!st_next.creg[CR_CA_HI]) begin
              st_next.ca = 1'b0;
              if (st_next.creg[CR_CA_LO]) begin
                st_next.ca = 1'b1;
                cap        = 1'b1;
              end
            end
            rd = (item.pin_a & ~st_next.ddpa) | (st_next.pa & st_next.ddpa);
          end
          REG_PB: rd = (item.pin_b & ~st_next.ddpb) | (st_next.pb & st_next.ddpb);
          REG_PC: begin
            if (st_next.creg[CR_IRQ_MODE]) begin
              rd = {2'b11, |st_next.air, st_next.pc[4:0]};
            end else begin
              rd = (item.pin_c & ~st_next.ddpc) | (st_next.pc & st_next.ddpc);
            end
          end
          REG_DDPA: rd = st_next.ddpa;
          REG_DDPB: rd = st_next.ddpb;
          REG_DDPC: rd = st_next.ddpc;
          REG_CREG: rd = st_next.creg;
          REG_AIR: begin
            // reading the active register acknowledges those sources
            rd            = st_next.air;
            st_next.pc    = st_next.pc & ~rd;
            st_next.stack = st_next.stack & ~rd[4:0];
            st_next.air   = 8'h00;
            if (!st_next.creg[CR_PRIO]) begin
              st_next.air   = {3'b000, st_next.stack};
              st_next.stack = 5'b00000;
            end
          end
          default: rd = 8'h00;
        endcase
      end
      ACT_WRITE: begin
        case (item.addr)
          REG_PA:   st_next.pa   = v;
          REG_DDPA: st_next.ddpa = v;
          REG_PB, REG_DDPB: begin
            if (item.addr == REG_PB) st_next.pb = v;
            else                     st_next.ddpb = v;
            if (!st_next.creg[CR_CB_HI]) begin
              st_next.cb = 1'b0;
              if (st_next.creg[CR_CB_LO]) begin
                st_next.cb = 1'b1;
                cbp        = 1'b1;
              end
            end
          end
          REG_PC: begin
            if (st_next.creg[CR_IRQ_MODE]) begin
              // clear latches written as zero
              st_next.pc = st_next.pc & v;
            end else begin
              st_next.pc      = v;
              st_next.pc_held = st_next.pc | ~st_next.ddpc;
            end
          end
          REG_DDPC: begin
            st_next.ddpc = v;
            if (st_next.creg[CR_IRQ_MODE]) begin
              // latched sources that are unmasked become active, highest line first
              for (int i = 4; i >= 0; i--) begin
                one_hot = 5'b00001 << i;
                if ((st_next.ddpc[4:0] & st_next.pc[4:0] & one_hot) != 5'b00000) begin
                  st_next = latch_source(st_next, one_hot);
                end
              end
            end else begin
              st_next.pc_held = st_next.pc | ~st_next.ddpc;
            end
          end
          REG_CREG: begin
            st_next.creg = v;
            if (v[CR_CA_HI])      st_next.ca = v[CR_CA_LO];
            else if (v[CR_CA_LO]) st_next.ca = 1'b1;
            if (v[CR_CB_HI])      st_next.cb = v[CR_CB_LO];
            else if (v[CR_CB_LO]) st_next.cb = 1'b1;
          end
          REG_AIR: begin
            // priority mode: highest stacked source becomes active
            if (st_next.creg[CR_PRIO]) begin
              for (int i = 0; i < 5; i++) begin
                if (st_next.stack[i]) st_next.air = 8'h01 << i;
              end
            end
          end
          default: ;
        endcase
      end
      ACT_LINE: begin
        if (item.irq_line < NUM_LINES) begin
          if (item.irq_level && ((st_next.line_prev & bsel) == 5'b00000)) begin
            if ((bsel[3] && st_next.creg[CR_EDGE3]) || (bsel[4] && st_next.creg[CR_EDGE4])) begin
              st_next = edge_latch(st_next, bsel);
            end
            st_next.line_prev = st_next.line_prev | bsel;
          end else if (!item.irq_level && ((st_next.line_prev & bsel) != 5'b00000)) begin
            if ((bsel[3] && !st_next.creg[CR_EDGE3]) ||
                (bsel[4] && !st_next.creg[CR_EDGE4])) begin
              st_next = edge_latch(st_next, bsel);
            end
            if (bsel[2:0] != 3'b000) begin
              st_next = latch_source(st_next, bsel);
            end
            st_next.line_prev = st_next.line_prev & ~bsel;
          end
        end
      end
      default: ;
    endcase
  end

  // Result from the updated state
  always_comb begin
    result.read_data  = rd;
    result.port_a_out = st_next.pa | ~st_next.ddpa;
    result.port_b_out = st_next.pb | ~st_next.ddpb;
    result.port_c_out = st_next.pc_held;
    result.ca_level   = st_next.ca;
    result.ca_pulse   = cap;
    result.cb_level   = st_next.cb;
    result.cb_pulse   = cbp;
    result.irq_out    = |st_next.air;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

endmodule

@@ sv/tpi_out_stage.sv @@
// ----------------------------------------------------------------------------
// tpi_out_stage
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module tpi_out_stage
  import tpi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  tpi_rsp_t   result,
  tpi_rsp_if.source  rsp,
  output logic       space
);

  // free when empty or being drained this cycle
  assign space = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.data <= result;
    end
  end

endmodule

@@ tb/tb_triport_interface_irq_controller_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triport_interface_irq_controller_top
// Self-checking bench for the tri-port interface with interrupt controller.
// Directed tests cover port I/O, the CA/CB handshake lines, and stacked and
// priority interrupts. Random bus and line traffic follows. A shadow copy of
// the register state predicts each result, and results are checked in order.
// ----------------------------------------------------------------------------
module tb_triport_interface_irq_controller_top;
  import tpi_pkg::*;

  localparam logic [1:0] ACT_NONE        = 2'd3;   // action code with no effect
  localparam logic [7:0] LINES_EDGE_SEL  = 8'h18;  // lines 3 and 4: edge from control
  localparam logic [7:0] LINES_FALL_ONLY = 8'h07;  // lines 0..2: falling edge only
  localparam int         CYCLE_LIMIT     = 200000;
  localparam int         DRAIN_CYCLES    = 6;

  logic clk;
  logic rst;

  tpi_cmd_if cmd_ch();
  tpi_rsp_if rsp_ch();

  triport_interface_irq_controller_top dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the block state
  logic [7:0] shadow_reg [8];
  logic [4:0] shadow_prev;
  logic [4:0] shadow_stack;
  logic [7:0] shadow_pc_held;
  logic       shadow_ca;
  logic       shadow_cb;

  tpi_rsp_t results_due [$];
  tpi_rsp_t want;
  bit       gaps_off = 1'b0;
  int       ready_stall;
  int       cycle_count;
  int       errors    = 0;
  int       n_checked = 0;
  int       n_reads   = 0;
  int       n_writes  = 0;
  int       n_lines   = 0;
  int       n_other   = 0;
  int       n_irq     = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int roll;
    if (gaps_off) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Latch one source; unmasked sources may become active
  function automatic void set_latch(input logic [7:0] b);
    shadow_reg[REG_PC] |= b;
    if ((shadow_reg[REG_DDPC] & b) == 8'h00) return;
    if (shadow_reg[REG_CREG][CR_PRIO]) begin
      if (b > (shadow_reg[REG_PC] & ~b)) shadow_reg[REG_AIR] = b;
    end else if (shadow_reg[REG_AIR] == 8'h00) begin
      shadow_reg[REG_AIR] = b;
    end
    shadow_stack |= b[4:0];
  endfunction

  // Edge on line 3 or 4 also raises CA / CB in toggle mode
  function automatic void latch_edge(input logic [7:0] b);
    set_latch(b);
    if (b[3] && shadow_reg[REG_CREG][CR_CA_HI:CR_CA_LO] == 2'b00) shadow_ca = 1'b1;
    if (b[4] && shadow_reg[REG_CREG][CR_CB_HI:CR_CB_LO] == 2'b00) shadow_cb = 1'b1;
  endfunction

  // Input pins where direction is 0, data register where 1
  function automatic logic [7:0] port_mix(input logic [7:0] pins,
                                          input logic [2:0] dreg, input logic [2:0] ddr);
    return (pins & ~shadow_reg[ddr]) | (shadow_reg[dreg] & shadow_reg[ddr]);
  endfunction

  function automatic tpi_rsp_t tpi_next_result(input tpi_cmd_t r);
    tpi_rsp_t   res;
    logic [7:0] creg;
    logic [7:0] b;
    int         i;
    res  = '0;
    creg = shadow_reg[REG_CREG];
    case (r.action)
      ACT_READ: begin
        case (r.addr)
          REG_PA: begin
            // port A read drives the CA handshake
            if (!creg[CR_CA_HI]) begin
              shadow_ca = 1'b0;
              if (creg[CR_CA_LO]) begin
                shadow_ca    = 1'b1;
                res.ca_pulse = 1'b1;
              end
            end
            res.read_data = port_mix(r.pin_a, REG_PA, REG_DDPA);
          end
          REG_PB: res.read_data = port_mix(r.pin_b, REG_PB, REG_DDPB);
          REG_PC: begin
            if (creg[CR_IRQ_MODE])
              res.read_data = {2'b11, |shadow_reg[REG_AIR], shadow_reg[REG_PC][4:0]};
            else
              res.read_data = port_mix(r.pin_c, REG_PC, REG_DDPC);
          end
          REG_AIR: begin
            // reading the active sources acknowledges them
            res.read_data = shadow_reg[REG_AIR];
            shadow_reg[REG_PC] &= ~res.read_data;
            shadow_stack &= ~res.read_data[4:0];
            shadow_reg[REG_AIR] = 8'h00;
            if (!creg[CR_PRIO]) begin
              shadow_reg[REG_AIR] = {3'b000, shadow_stack};
              shadow_stack = 5'h00;
            end
          end
          default: res.read_data = shadow_reg[r.addr];
        endcase
      end
      ACT_WRITE: begin
        case (r.addr)
          REG_PA, REG_DDPA: shadow_reg[r.addr] = r.write_data;
          REG_PB, REG_DDPB: begin
            // port B write drives the CB handshake
            shadow_reg[r.addr] = r.write_data;
            if (!creg[CR_CB_HI]) begin
              shadow_cb = 1'b0;
              if (creg[CR_CB_LO]) begin
                shadow_cb    = 1'b1;
                res.cb_pulse = 1'b1;
              end
            end
          end
          REG_PC, REG_DDPC: begin
            if (!creg[CR_IRQ_MODE]) begin
              shadow_reg[r.addr] = r.write_data;
              shadow_pc_held = shadow_reg[REG_PC] | ~shadow_reg[REG_DDPC];
            end else if (r.addr == REG_PC) begin
              // zero bits clear latches, the byte is not stored
              shadow_reg[REG_PC] &= r.write_data;
            end else begin
              // new masks: latched sources now unmasked are raised
              shadow_reg[REG_DDPC] = r.write_data;
              for (i = 4; i >= 0; i--) begin
                b = 8'd1 << i;
                if ((shadow_reg[REG_DDPC] & shadow_reg[REG_PC] & b) != 8'h00) set_latch(b);
              end
            end
          end
          REG_CREG: begin
            shadow_reg[REG_CREG] = r.write_data;
            if (r.write_data[CR_CA_HI]) shadow_ca = r.write_data[CR_CA_LO];
            else if (r.write_data[CR_CA_LO]) shadow_ca = 1'b1;
            if (r.write_data[CR_CB_HI]) shadow_cb = r.write_data[CR_CB_LO];
            else if (r.write_data[CR_CB_LO]) shadow_cb = 1'b1;
          end
          default: begin
            // active register write: priority mode raises the top pending source
            if (creg[CR_PRIO]) begin
              for (i = 4; i >= 0; i--) begin
                if (shadow_stack[i]) begin
                  shadow_reg[REG_AIR] = 8'd1 << i;
                  break;
                end
              end
            end
          end
        endcase
      end
      ACT_LINE: begin
        if (r.irq_line < NUM_LINES) begin
          b = 8'd1 << r.irq_line;
          if (r.irq_level && (shadow_prev & b[4:0]) == 5'h00) begin
            if ((b & LINES_EDGE_SEL) != 8'h00 && ((b >> 1) & creg) != 8'h00) latch_edge(b);
            shadow_prev |= b[4:0];
          end else if (!r.irq_level && (shadow_prev & b[4:0]) != 5'h00) begin
            if ((b & LINES_EDGE_SEL) != 8'h00 && ((b >> 1) & creg) == 8'h00) latch_edge(b);
            if ((b & LINES_FALL_ONLY) != 8'h00) set_latch(b);
            shadow_prev &= ~b[4:0];
          end
        end
      end
      default: ;
    endcase
    res.port_a_out = shadow_reg[REG_PA] | ~shadow_reg[REG_DDPA];
    res.port_b_out = shadow_reg[REG_PB] | ~shadow_reg[REG_DDPB];
    res.port_c_out = shadow_pc_held;
    res.ca_level   = shadow_ca;
    res.cb_level   = shadow_cb;
    res.irq_out    = |shadow_reg[REG_AIR];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors
  // ---------------------------------------------------------------------------

  // Predict on every accepted request
  always @(posedge clk) begin
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      results_due.push_back(tpi_next_result(cmd_ch.data));
      case (cmd_ch.data.action)
        ACT_READ:  n_reads++;
        ACT_WRITE: n_writes++;
        ACT_LINE:  n_lines++;
        default:   n_other++;
      endcase
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want_v,
                                      input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %02h, got %02h", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: result %h with none expected", $time, rsp_ch.data);
        errors++;
      end else begin
        want = results_due.pop_front();
        check_field("read_data", want.read_data, rsp_ch.data.read_data);
        check_field("port_a_out", want.port_a_out, rsp_ch.data.port_a_out);
        check_field("port_b_out", want.port_b_out, rsp_ch.data.port_b_out);
        check_field("port_c_out", want.port_c_out, rsp_ch.data.port_c_out);
        check_field("ca_level", 8'(want.ca_level), 8'(rsp_ch.data.ca_level));
        check_field("ca_pulse", 8'(want.ca_pulse), 8'(rsp_ch.data.ca_pulse));
        check_field("cb_level", 8'(want.cb_level), 8'(rsp_ch.data.cb_level));
        check_field("cb_pulse", 8'(want.cb_pulse), 8'(rsp_ch.data.cb_pulse));
        check_field("irq_out", 8'(want.irq_out), 8'(rsp_ch.data.irq_out));
        n_checked++;
        if (want.irq_out) n_irq++;
      end
    end
  end

  // Result sink with random stalls
  initial begin
    forever begin
      ready_stall = pick_gap();
      if (ready_stall == 0) begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b0;
        repeat (ready_stall) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driving
  // ---------------------------------------------------------------------------

  function automatic tpi_cmd_t rand_req();
    tpi_cmd_t r;
    r.action     = 2'($urandom);
    r.addr       = 3'($urandom);
    r.write_data = 8'($urandom);
    r.pin_a      = 8'($urandom);
    r.pin_b      = 8'($urandom);
    r.pin_c      = 8'($urandom);
    r.irq_line   = 3'($urandom);
    r.irq_level  = 1'($urandom);
    return r;
  endfunction

  // Present one request and hold it until accepted
  task automatic send_req(input tpi_cmd_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= r;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  task automatic do_write(input logic [2:0] a, input logic [7:0] v);
    tpi_cmd_t r;
    r            = rand_req();
    r.action     = ACT_WRITE;
    r.addr       = a;
    r.write_data = v;
    send_req(r);
  endtask

  task automatic do_read(input logic [2:0] a, input logic [7:0] pins);
    tpi_cmd_t r;
    r        = rand_req();
    r.action = ACT_READ;
    r.addr   = a;
    r.pin_a  = pins;
    r.pin_b  = pins;
    r.pin_c  = pins;
    send_req(r);
  endtask

  task automatic do_line(input logic [2:0] ln, input logic lvl);
    tpi_cmd_t r;
    r           = rand_req();
    r.action    = ACT_LINE;
    r.irq_line  = ln;
    r.irq_level = lvl;
    send_req(r);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Data/direction mixing on all three ports, pin extremes
  task automatic test_port_io();
    do_write(REG_DDPA, 8'hF0);
    do_read(REG_PA, 8'h00);
    do_read(REG_PA, 8'hFF);
    do_write(REG_PB, 8'hFF);
    do_write(REG_DDPB, 8'h0F);
    do_read(REG_PB, 8'h5A);
    do_write(REG_PC, 8'hA5);
    do_write(REG_DDPC, 8'h3C);
    do_read(REG_PC, 8'h00);
  endtask

  // CA pulse on port A read, CB pulse on port B writes, manual levels
  task automatic test_handshake_lines();
    do_write(REG_CREG, 8'h50);
    do_read(REG_PA, 8'hFF);
    do_write(REG_DDPB, 8'h00);
    do_write(REG_CREG, 8'hF0);
    do_write(REG_CREG, 8'hA0);
    do_read(REG_PA, 8'h00);
  endtask

  // Stacked mode: latches, masks, acknowledge, latch clearing, ignored line
  task automatic test_irq_stacked();
    do_write(REG_CREG, 8'h01);
    do_write(REG_DDPC, 8'h1F);
    do_line(3'd0, 1'b0);
    do_line(3'd3, 1'b0);
    do_line(3'd6, 1'b0);
    do_read(REG_PC, 8'h00);
    do_read(REG_AIR, 8'h00);
    do_read(REG_AIR, 8'hFF);
    do_line(3'd2, 1'b0);
    do_write(REG_PC, 8'h00);
  endtask

  // Priority mode: rising edge on line 4 wins, active register write re-raises
  task automatic test_irq_priority();
    do_write(REG_CREG, 8'h0F);
    do_line(3'd4, 1'b0);
    do_line(3'd1, 1'b0);
    do_line(3'd4, 1'b1);
    do_write(REG_AIR, 8'h00);
    do_read(REG_AIR, 8'h00);
    do_write(REG_AIR, 8'hFF);
    do_read(REG_AIR, 8'hFF);
  endtask

  // Unused action code, ignored line, plain register read
  task automatic test_odd_requests();
    tpi_cmd_t r;
    r        = rand_req();
    r.action = ACT_NONE;
    send_req(r);
    do_line(3'd7, 1'b1);
    do_read(REG_CREG, 8'h00);
  endtask

  // Random mix of edges, acknowledges, mask and control writes
  task automatic test_random_traffic(input int count, input bit irq_focus);
    tpi_cmd_t r;
    int       sel;
    int       pick;
    for (int n = 0; n < count; n++) begin
      r   = rand_req();
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        r.action   = ACT_LINE;
        r.irq_line = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4));
      end else if (sel < 55) begin
        r.action = ACT_READ;
        pick     = $urandom_range(0, 4);
        if (pick < 2) r.addr = REG_AIR;
        else if (pick == 2) r.addr = REG_PC;
        else if (pick == 3) r.addr = REG_PA;
      end else if (sel < 60) begin
        r.action = ACT_WRITE;
        r.addr   = REG_AIR;
      end else if (sel < 70) begin
        r.action = ACT_WRITE;
        r.addr   = REG_CREG;
        if (irq_focus) r.write_data[CR_IRQ_MODE] = 1'b1;
      end else if (sel < 80) begin
        r.action = ACT_WRITE;
        r.addr   = REG_DDPC;
        if ($urandom_range(0, 1)) r.write_data[4:0] = 5'h1F;
      end else if (sel < 85) begin
        r.action = ACT_WRITE;
        r.addr   = REG_PC;
      end else if (sel < 96) begin
        r.action = ACT_WRITE;
        r.addr   = 3'($urandom_range(0, 5));
      end else begin
        r.action = ACT_NONE;
      end
      send_req(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    rst          = 1'b1;
    for (int k = 0; k < 8; k++) shadow_reg[3'(k)] = 8'h00;
    shadow_prev    = 5'h1F;
    shadow_stack   = 5'h00;
    shadow_pc_held = 8'hFF;
    shadow_ca      = 1'b0;
    shadow_cb      = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_port_io();
    test_handshake_lines();
    test_irq_stacked();
    test_irq_priority();
    test_odd_requests();
    test_random_traffic(200, 1'b0);
    gaps_off = 1'b1;
    test_random_traffic(100, 1'b1);
    gaps_off = 1'b0;
    test_random_traffic(214, 1'b1);

    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Requests: %0d reads, %0d writes, %0d line events, %0d no-ops",
             n_reads, n_writes, n_lines, n_other);
    $display("Results checked: %0d, with interrupt active: %0d, errors: %0d",
             n_checked, n_irq, errors);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
